/* design/rbb_pkg.sv */
// shared constants for the rgb box blur: field widths, stream packing, register map
// no dependencies
package rbb_pkg;

  localparam int PIX_W          = 8;
  localparam int POS_W          = 10;
  localparam int CFG_W          = 11;
  localparam int IN_TDATA_W     = 24;
  localparam int OUT_TDATA_W    = 48;
  localparam int APB_AW         = 3;
  localparam int APB_DW         = 32;

  localparam int KERNEL_SIZE_DEF = 15;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 1024;

  // register index, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

endpackage

/* design/rbb_ram.sv */
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module rbb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/rgb_box_blur_clipped_edges_top.sv */
// rgb box blur with clipped edges: line store in ram, window summed by reads,
// mean taken by serial dividers, one per colour channel; uses rbb_pkg and rbb_ram
//
//  channel | dir | handshake                  | content
//  s_*     | in  | tvalid/tready              | tdata: red[7:0] green[15:8] blue[23:16]
//  m_*     | out | tvalid/tready              | tdata: red, green, blue, row[33:24],
//          |     |                            | col[43:34], zero pad; tlast: last of run
//  apb     | in  | psel/penable/pwrite/pready | 0x0 frame_width, 0x4 frame_height
//
// each pixel request is written to the line store when it is accepted; a pixel that
// completes windows then yields results one by one, each from one line store read per
// window pixel through the single ram read port, then one quotient bit per cycle in
// the divider over a SUMW-bit sum (SUMW = 16 at default size)
// the output register holds a finished result while the next one is computed
// requests are held off during the access cycle of a register write
// reset (synchronous) restores the full frame size and restarts at row 0, column 0;
// the line store is never cleared, only pixels of the current frame are read back
module rgb_box_blur_clipped_edges_top #(
  parameter int KERNEL_SIZE = rbb_pkg::KERNEL_SIZE_DEF,
  parameter int MAX_WIDTH   = rbb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = rbb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rbb_pkg::IN_TDATA_W-1:0]   s_tdata,   // red, green, blue
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [rbb_pkg::OUT_TDATA_W-1:0]  m_tdata,   // red, green, blue, row, col, pad
  output logic                             m_tlast,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rbb_pkg::APB_AW-1:0]       paddr,
  input  logic [rbb_pkg::APB_DW-1:0]       pwdata,
  output logic [rbb_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);
  import rbb_pkg::*;

  localparam int HALF    = KERNEL_SIZE / 2;
  localparam int LS      = 2 * HALF + 1;
  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int WW      = XW + 1;
  localparam int HW      = YW + 1;
  localparam int SW      = (LS > 1) ? $clog2(LS) : 1;
  localparam int DEPTH   = LS * MAX_WIDTH;
  localparam int AW      = $clog2(DEPTH);
  localparam int CNT_MAX = LS * LS;
  localparam int CNTW    = $clog2(CNT_MAX + 1);
  localparam int SUMW    = $clog2(CNT_MAX * ((1 << PIX_W) - 1) + 1);
  localparam int STW     = $clog2(SUMW + 1);
  localparam int KW      = $clog2(LS + 1);

  typedef enum logic [2:0] {IDLE, SETUP, SCAN, DRAIN, DIV, EMIT} state_t;

  state_t state;

  // configuration and input position
  logic [WW-1:0] fwidth;
  logic [HW-1:0] fheight;
  logic [YW-1:0] in_r;
  logic [XW-1:0] in_c;
  logic [SW-1:0] in_slot;

  // burst bounds and current output pixel
  logic [YW-1:0] cur_r, rr, rhi;
  logic [XW-1:0] clo, cc, chi;
  logic [SW-1:0] cur_slot;

  // window scan
  logic [YW-1:0] y, y1;
  logic [XW-1:0] x, x0, x1;
  logic [SW-1:0] slot;
  logic [CNTW-1:0] count;
  logic          rd_valid;
  logic [SUMW-1:0] acc [3];

  // divider
  logic [SUMW-1:0] dvd [3];
  logic [CNTW-1:0] rem [3];
  logic [STW-1:0]  step;

  // output register
  logic [PIX_W-1:0] o_pix [3];
  logic [POS_W-1:0] o_row, o_col;
  logic             o_last;

  logic [3*PIX_W-1:0] rd_data;

  function automatic logic [31:0] clamp_dim(logic [CFG_W-1:0] v, int max_v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) begin
      return 32'd1;
    end
    if (w > 32'(max_v)) begin
      return 32'(max_v);
    end
    return w;
  endfunction

  // ---------------- request side: position, burst bounds ----------------
  logic          accept, cfg_wr, wrap, last_row, last_col, r_ge, c_ge, rows_ok, cols_ok;
  logic [YW-1:0] r_eff, rlo_a, rhi_a;
  logic [XW-1:0] c_eff, clo_a, chi_a;
  logic [SW-1:0] slot_eff;
  logic [YW-1:0] r_next;
  logic [XW-1:0] c_next;
  logic [SW-1:0] slot_next;
  logic [AW-1:0] wr_addr;

  assign accept = s_tvalid && s_tready;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    wrap     = ({1'b0, in_r} >= fheight) || ({1'b0, in_c} >= fwidth);
    r_eff    = wrap ? '0 : in_r;
    c_eff    = wrap ? '0 : in_c;
    slot_eff = wrap ? '0 : in_slot;
    last_row = (HW'(r_eff) + HW'(1)) >= fheight;
    last_col = (WW'(c_eff) + WW'(1)) >= fwidth;
    r_ge     = HW'(r_eff) >= HW'(HALF);
    c_ge     = WW'(c_eff) >= WW'(HALF);
    rows_ok  = last_row || r_ge;
    cols_ok  = last_col || c_ge;
    rlo_a    = r_ge ? r_eff - YW'(HALF) : '0;
    clo_a    = c_ge ? c_eff - XW'(HALF) : '0;
    rhi_a    = last_row ? r_eff : rlo_a;
    chi_a    = last_col ? c_eff : clo_a;
    r_next    = r_eff;
    c_next    = c_eff + XW'(1);
    slot_next = slot_eff;
    if (last_col) begin
      c_next = '0;
      if (last_row) begin
        r_next    = '0;
        slot_next = '0;
      end else begin
        r_next    = r_eff + YW'(1);
        slot_next = (slot_eff == SW'(LS - 1)) ? '0 : slot_eff + SW'(1);
      end
    end
    wr_addr = AW'(slot_eff) * AW'(MAX_WIDTH) + AW'(c_eff);
  end

  // ---------------- window bounds of the current output pixel ----------------
  logic [YW-1:0] y0_s, y1_s, dy;
  logic [XW-1:0] x0_s, x1_s;
  logic [HW-1:0] ysum;
  logic [WW-1:0] xsum;
  logic [SW-1:0] dd, slot0;
  logic [CNTW-1:0] count_s;

  always_comb begin
    y0_s = (HW'(rr) >= HW'(HALF)) ? rr - YW'(HALF) : '0;
    x0_s = (WW'(cc) >= WW'(HALF)) ? cc - XW'(HALF) : '0;
    ysum = HW'(rr) + HW'(HALF);
    xsum = WW'(cc) + WW'(HALF);
    y1_s = (ysum < fheight) ? YW'(ysum) : YW'(fheight - HW'(1));
    x1_s = (xsum < fwidth) ? XW'(xsum) : XW'(fwidth - WW'(1));
    dy   = cur_r - y0_s;
    dd   = SW'(dy);
    // window top row sits at most 2*HALF rows above the input row
    slot0 = (cur_slot >= dd) ? cur_slot - dd
                             : SW'({1'b0, cur_slot} + (SW+1)'(LS) - {1'b0, dd});
    count_s = CNTW'(KW'(y1_s - y0_s) + KW'(1)) * CNTW'(KW'(x1_s - x0_s) + KW'(1));
  end

  // ---------------- line store ----------------
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  assign rd_en   = (state == SCAN);
  assign rd_addr = AW'(slot) * AW'(MAX_WIDTH) + AW'(x);

  rbb_ram #(
    .WIDTH (3 * PIX_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wr_addr),
    .wr_data (s_tdata[3*PIX_W-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  logic [SUMW-1:0] acc_sum [3];
  logic [CNTW:0]   trial [3];
  logic            scan_done, burst_done, out_free;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_sum[k] = acc[k] + SUMW'(rd_data[k*PIX_W +: PIX_W]);
      trial[k]   = {rem[k], dvd[k][SUMW-1]};
    end
  end

  assign scan_done  = (y == y1) && (x == x1);
  assign burst_done = (rr == rhi) && (cc == chi);
  assign out_free   = !m_tvalid || m_tready;

  // ---------------- control and datapath registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
      fwidth   <= WW'(MAX_WIDTH);
      fheight  <= HW'(MAX_HEIGHT);
      in_r     <= '0;
      in_c     <= '0;
      in_slot  <= '0;
      rd_valid <= 1'b0;
    end else begin
      // a result taken while no new one is loaded empties the output register
      if (m_tvalid && m_tready && !(state == EMIT && out_free)) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_wr) begin
        unique case (paddr[2])
          REG_WIDTH:  fwidth  <= WW'(clamp_dim(pwdata[CFG_W-1:0], MAX_WIDTH));
          REG_HEIGHT: fheight <= HW'(clamp_dim(pwdata[CFG_W-1:0], MAX_HEIGHT));
          default: ;
        endcase
        in_r    <= '0;
        in_c    <= '0;
        in_slot <= '0;
      end

      unique case (state)
        IDLE: begin
          if (accept) begin
            in_r    <= r_next;
            in_c    <= c_next;
            in_slot <= slot_next;
            if (rows_ok && cols_ok) begin
              cur_r    <= r_eff;
              cur_slot <= slot_eff;
              rr       <= rlo_a;
              rhi      <= rhi_a;
              cc       <= clo_a;
              clo      <= clo_a;
              chi      <= chi_a;
              state    <= SETUP;
            end
          end
        end
        SETUP: begin
          y     <= y0_s;
          y1    <= y1_s;
          x     <= x0_s;
          x0    <= x0_s;
          x1    <= x1_s;
          slot  <= slot0;
          count <= count_s;
          for (int k = 0; k < 3; k++) begin
            acc[k] <= '0;
          end
          rd_valid <= 1'b0;
          state    <= SCAN;
        end
        SCAN: begin
          rd_valid <= 1'b1;
          if (rd_valid) begin
            for (int k = 0; k < 3; k++) begin
              acc[k] <= acc_sum[k];
            end
          end
          if (scan_done) begin
            state <= DRAIN;
          end else if (x == x1) begin
            x    <= x0;
            y    <= y + YW'(1);
            slot <= (slot == SW'(LS - 1)) ? '0 : slot + SW'(1);
          end else begin
            x <= x + XW'(1);
          end
        end
        DRAIN: begin
          // last read lands here, goes straight into the divider
          for (int k = 0; k < 3; k++) begin
            dvd[k] <= acc_sum[k];
            rem[k] <= '0;
          end
          step  <= '0;
          state <= DIV;
        end
        DIV: begin
          for (int k = 0; k < 3; k++) begin
            if (trial[k] >= {1'b0, count}) begin
              rem[k] <= CNTW'(trial[k] - {1'b0, count});
              dvd[k] <= {dvd[k][SUMW-2:0], 1'b1};
            end else begin
              rem[k] <= CNTW'(trial[k]);
              dvd[k] <= {dvd[k][SUMW-2:0], 1'b0};
            end
          end
          step <= step + STW'(1);
          if (step == STW'(SUMW - 1)) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (out_free) begin
            for (int k = 0; k < 3; k++) begin
              o_pix[k] <= dvd[k][PIX_W-1:0];
            end
            o_row    <= POS_W'(rr);
            o_col    <= POS_W'(cc);
            o_last   <= burst_done;
            m_tvalid <= 1'b1;
            if (burst_done) begin
              state <= IDLE;
            end else begin
              if (cc == chi) begin
                cc <= clo;
                rr <= rr + YW'(1);
              end else begin
                cc <= cc + XW'(1);
              end
              state <= SETUP;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign s_tready = (state == IDLE) && !cfg_wr;
  assign m_tdata  = {(OUT_TDATA_W - 3*PIX_W - 2*POS_W)'(0), o_col, o_row,
                     o_pix[2], o_pix[1], o_pix[0]};
  assign m_tlast  = o_last;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_HEIGHT) ? APB_DW'(fheight) : APB_DW'(fwidth);

endmodule

/* design/rbb_checker.sv */
// port-level checks for the rgb box blur top level, attached by bind
// depends on rbb_pkg
module rbb_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [rbb_pkg::IN_TDATA_W-1:0]   s_tdata,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [rbb_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic                             m_tlast
);

  // stalled result keeps valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // stalled result keeps payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // no new request taken while a burst is still being delivered
  a_burst_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("request taken in the middle of a burst");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result visible after reset");

endmodule

bind rgb_box_blur_clipped_edges_top rbb_checker u_rbb_checker (.*);
